/* hdl/grid_component_crystal_count_defines.svh */
// Assertion macros for the grid component crystal counter.
`ifndef GRID_COMPONENT_CRYSTAL_COUNT_DEFINES_SVH
`define GRID_COMPONENT_CRYSTAL_COUNT_DEFINES_SVH
`ifndef SYNTHESIS
`define GCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/gcc_pkg.sv */
// Shared types and constants for the grid component crystal counter.
package gcc_pkg;
  localparam int unsigned DefMaxRows = 512;
  localparam int unsigned DefMaxCols = 512;
  localparam int unsigned CountW = 19;
  localparam int unsigned RankW = 5;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [RankW-1:0] RankMax = '1;
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdQuery = 1'b1;
  localparam logic [1:0] KindWall = 2'd0;
  localparam logic [1:0] KindEmpty = 2'd1;
  localparam logic [1:0] KindCrystal = 2'd2;
  localparam logic [1:0] KindSpare = 2'd3;
endpackage

/* hdl/gcc_ram.sv */
// Generic single-port RAM with registered read.
module gcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hdl/grid_component_crystal_count.sv */
// Top level: union-find crystal counter over a grid with one table memory.
// Each cell occupies one memory entry {open, parent, rank, count}. A load
// writes the cell, then for each open left/up neighbor walks both cells to
// their roots, reading one parent at a time, and links them by rank, summing
// counts. A join checks the neighbor (S_NB, S_NBCHK), reads and checks each
// node on each root walk (S_FA/S_FAW, S_FB/S_FBW) and links the roots in
// S_LINK, S_LINK2 and S_LINK3. With trees built by raster loading a walk
// visits at most log2(cells)+1 nodes; reloading a cell can lengthen paths
// beyond that. A query reads and checks each node on its path (S_QA/S_QAW)
// and then raises out_valid in S_OUT. The single memory port sets the
// rate. A result waits in an output register, and no new transaction is
// taken until it is accepted.
module grid_component_crystal_count #(
  parameter int unsigned MAX_ROWS = gcc_pkg::DefMaxRows,
  parameter int unsigned MAX_COLS = gcc_pkg::DefMaxCols
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [8:0]  in_row,
  input  logic [8:0]  in_col,
  input  logic [1:0]  in_cell_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [gcc_pkg::CountW-1:0] out_crystal_count
);
  import gcc_pkg::*;
  `include "grid_component_crystal_count_defines.svh"

  localparam int unsigned Cells = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = $clog2(Cells);
  localparam int unsigned EW = 1 + AW + RankW + CountW;

  typedef enum logic [3:0] {
    S_IDLE, S_LDW, S_NB, S_NBCHK, S_FA, S_FAW, S_FB, S_FBW, S_LINK, S_LINK2,
    S_LINK3, S_QA, S_QAW, S_OUT
  } state_t;

  typedef struct packed {
    logic            open;
    logic [AW-1:0]   parent;
    logic [RankW-1:0] rank;
    logic [CountW-1:0] count;
  } entry_t;

  state_t state_r;
  logic [AW-1:0] idx_r, a_r, b_r, ra_r, rb_r, addr;
  entry_t ea_r, rd, wd;
  logic we, up_r, kind_open_r, kind_cry_r;
  logic [8:0] row_r, col_r;
  logic [CountW-1:0] res_r;
  logic out_valid_r;
  logic [EW-1:0] rdata;
  logic [CountW:0] sum;
  logic [AW-1:0] rdp;
  logic link_wr;

  assign rd = entry_t'(rdata);
  assign rdp = rd.parent;
  assign link_wr = (state_r == S_LINK2) || (state_r == S_LINK3);

  gcc_ram #(.Width(EW), .Depth(Cells)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wd), .rdata(rdata)
  );

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_crystal_count = res_r;

  always_comb begin
    sum = {1'b0, ea_r.count} + {1'b0, rd.count};
  end

  always_comb begin
    we = 1'b0;
    addr = a_r;
    wd = ea_r;
    case (state_r)
      S_LDW: begin
        we = 1'b1;
        addr = idx_r;
        wd = '{open: kind_open_r, parent: idx_r, rank: '0,
               count: kind_cry_r ? CountW'(1) : '0};
      end
      S_NB: addr = b_r;
      S_FA: addr = a_r;
      S_FB: addr = b_r;
      S_LINK: addr = rb_r;
      S_LINK2: begin
        we = 1'b1;
        if (ea_r.rank > rd.rank) begin
          addr = ra_r;
          wd = ea_r;
          wd.count = sum[CountW] ? CountMax : sum[CountW-1:0];
        end else begin
          addr = rb_r;
          wd = rd;
          wd.count = sum[CountW] ? CountMax : sum[CountW-1:0];
          if (ea_r.rank == rd.rank && rd.rank != RankMax) begin
            wd.rank = rd.rank + RankW'(1);
          end
        end
      end
      S_LINK3: we = 1'b1;
      S_QA: addr = a_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_ready) out_valid_r <= 1'b0;
          if (in_valid && in_ready) begin
            row_r <= in_row;
            col_r <= in_col;
            kind_open_r <= (in_cell_kind == KindEmpty) || (in_cell_kind == KindCrystal);
            kind_cry_r <= in_cell_kind == KindCrystal;
            idx_r <= AW'(32'(in_row) * MAX_COLS + 32'(in_col));
            a_r <= AW'(32'(in_row) * MAX_COLS + 32'(in_col));
            if (32'(in_row) >= MAX_ROWS || 32'(in_col) >= MAX_COLS) begin
              if (in_command == CmdQuery) begin
                res_r <= '0;
                state_r <= S_OUT;
              end
            end else begin
              state_r <= (in_command == CmdLoad) ? S_LDW : S_QA;
            end
          end
        end
        S_LDW: begin
          up_r <= 1'b0;
          if (!kind_open_r) state_r <= S_IDLE;
          else if (col_r != 0) begin
            b_r <= idx_r - AW'(1);
            state_r <= S_NB;
          end else if (row_r != 0) begin
            up_r <= 1'b1;
            b_r <= idx_r - AW'(MAX_COLS);
            state_r <= S_NB;
          end else state_r <= S_IDLE;
        end
        S_NB: state_r <= S_NBCHK;
        S_NBCHK: begin
          if (rd.open) begin
            a_r <= idx_r;
            state_r <= S_FA;
          end else if (!up_r && row_r != 0) begin
            up_r <= 1'b1;
            b_r <= idx_r - AW'(MAX_COLS);
            state_r <= S_NB;
          end else state_r <= S_IDLE;
        end
        S_FA: state_r <= S_FAW;
        S_FAW: begin
          if (rdp == a_r || 32'(rdp) >= Cells) begin
            ra_r <= a_r;
            ea_r <= rd;
            state_r <= S_FB;
          end else begin
            a_r <= rdp;
            state_r <= S_FA;
          end
        end
        S_FB: state_r <= S_FBW;
        S_FBW: begin
          if (rdp == b_r || 32'(rdp) >= Cells) begin
            rb_r <= b_r;
            if (b_r != ra_r) begin
              state_r <= S_LINK;
            end else if (!up_r && row_r != 0) begin
              up_r <= 1'b1;
              b_r <= idx_r - AW'(MAX_COLS);
              state_r <= S_NB;
            end else state_r <= S_IDLE;
          end else begin
            b_r <= rdp;
            state_r <= S_FB;
          end
        end
        S_LINK: begin
          state_r <= S_LINK2;
        end
        S_LINK2: begin
          if (ea_r.rank > rd.rank) begin
            a_r <= rb_r;
            ea_r <= '{open: rd.open, parent: ra_r, rank: rd.rank, count: rd.count};
          end else begin
            a_r <= ra_r;
            ea_r <= '{open: ea_r.open, parent: rb_r, rank: ea_r.rank, count: ea_r.count};
          end
          state_r <= S_LINK3;
        end
        S_LINK3: begin
          if (!up_r && row_r != 0) begin
            up_r <= 1'b1;
            b_r <= idx_r - AW'(MAX_COLS);
            state_r <= S_NB;
          end else state_r <= S_IDLE;
        end
        S_QA: state_r <= S_QAW;
        S_QAW: begin
          if (a_r == idx_r && !rd.open) begin
            res_r <= '0;
            state_r <= S_OUT;
          end else if (rdp == a_r || 32'(rdp) >= Cells) begin
            res_r <= rd.count;
            state_r <= S_OUT;
          end else begin
            a_r <= rdp;
            state_r <= S_QA;
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GCC_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `GCC_ASSERT_NEXT(a_out_from_out, clk, rst_n, state_r == S_OUT, out_valid)
  `GCC_ASSERT_IMPL(a_write_states, clk, rst_n, we, state_r == S_LDW || link_wr)
endmodule

/* dv/grid_component_crystal_count_tb.sv */
// Self-checking testbench for the grid component crystal counter.
module grid_component_crystal_count_tb;
  import gcc_pkg::*;

  localparam int unsigned Cols = DefMaxCols;
  localparam int unsigned Cells = DefMaxRows * DefMaxCols;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic       command;
    logic [8:0] row;
    logic [8:0] col;
    logic [1:0] cell_kind;
  } cell_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CmdLoad;
  logic [8:0] in_row = '0;
  logic [8:0] in_col = '0;
  logic [1:0] in_cell_kind = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CountW-1:0] out_crystal_count;

  grid_component_crystal_count i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_cell_kind     (in_cell_kind),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_crystal_count(out_crystal_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cell_op_t pending_ops[$];
  logic [CountW-1:0] expected_counts[$];
  int unsigned loaded_cells[$];
  bit was_loaded[Cells];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  bit open_cell[Cells];
  int unsigned parent_of[Cells];
  int unsigned rank_of[Cells];
  int unsigned count_of[Cells];

  function automatic int unsigned root_of(int unsigned v);
    int unsigned steps;
    int unsigned up;
    steps = 0;
    while (steps < Cells) begin
      up = parent_of[v];
      if (up >= Cells || up == v) break;
      v = up;
      steps++;
    end
    return v;
  endfunction

  function automatic int unsigned add_sat(int unsigned a, int unsigned b);
    return (a + b > CountMax) ? CountMax : a + b;
  endfunction

  function automatic void merge_cells(int unsigned a, int unsigned b);
    int unsigned ra;
    int unsigned rb;
    ra = root_of(a);
    rb = root_of(b);
    if (ra == rb) return;
    if (rank_of[ra] > rank_of[rb]) begin
      parent_of[rb] = ra;
      count_of[ra] = add_sat(count_of[ra], count_of[rb]);
    end else begin
      parent_of[ra] = rb;
      count_of[rb] = add_sat(count_of[rb], count_of[ra]);
      if (rank_of[ra] == rank_of[rb] && rank_of[rb] < RankMax) rank_of[rb]++;
    end
  endfunction

  function automatic void apply_cell_op(cell_op_t op);
    int unsigned idx;
    bit is_open;
    idx = op.row * Cols + op.col;
    if (op.command == CmdLoad) begin
      is_open = (op.cell_kind == KindEmpty || op.cell_kind == KindCrystal);
      open_cell[idx] = is_open;
      parent_of[idx] = idx;
      rank_of[idx] = 0;
      count_of[idx] = (op.cell_kind == KindCrystal) ? 1 : 0;
      if (is_open) begin
        if (op.col > 0 && open_cell[idx-1]) merge_cells(idx, idx - 1);
        if (op.row > 0 && open_cell[idx-Cols]) merge_cells(idx, idx - Cols);
      end
    end else begin
      expected_counts.push_back(open_cell[idx] ? CountW'(count_of[root_of(idx)]) : '0);
    end
  endfunction

  task automatic push_load(int unsigned r, int unsigned c, logic [1:0] k);
    cell_op_t op;
    op.command = CmdLoad;
    op.row = 9'(r);
    op.col = 9'(c);
    op.cell_kind = k;
    pending_ops.push_back(op);
    if (!was_loaded[r*Cols+c]) begin
      was_loaded[r*Cols+c] = 1'b1;
      loaded_cells.push_back(r*Cols+c);
    end
  endtask

  task automatic push_query(int unsigned idx);
    cell_op_t op;
    op.command = CmdQuery;
    op.row = 9'(idx / Cols);
    op.col = 9'(idx % Cols);
    op.cell_kind = 2'($urandom_range(3, 0));
    pending_ops.push_back(op);
  endtask

  task automatic push_random_query();
    push_query(loaded_cells[$urandom_range(loaded_cells.size() - 1, 0)]);
  endtask

  task automatic load_grid(int unsigned rows, int unsigned cols, int unsigned q_pct);
    for (int unsigned r = 0; r < rows; r++)
      for (int unsigned c = 0; c < cols; c++) begin
        push_load(r, c, ($urandom_range(99, 0) < 70) ? 2'($urandom_range(2, 1))
                      : (($urandom_range(1, 0) != 0) ? KindSpare : KindWall));
        if ($urandom_range(99, 0) < q_pct) push_random_query();
      end
  endtask

  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_cell_op(pending_ops.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_ops.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_command <= pending_ops[0].command;
          in_row <= pending_ops[0].row;
          in_col <= pending_ops[0].col;
          in_cell_kind <= pending_ops[0].cell_kind;
          if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 0);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  int unsigned stall_phase = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(300, 20);
      stall_mode = $urandom_range(3, 0);
    end else begin
      stall_phase--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(3, 0) != 0);
      2: out_ready <= ($urandom_range(3, 0) == 0);
      default: out_ready <= cycles[4];
    endcase
    if (rst_n && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: count %0d", out_crystal_count);
      end else if (out_crystal_count !== expected_counts[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("crystal_count mismatch: expected %0d, actual %0d",
                   expected_counts[0], out_crystal_count);
        void'(expected_counts.pop_front());
      end else begin
        void'(expected_counts.pop_front());
      end
    end
  end

  initial begin
    // directed: small grid with every kind, then query every cell
    push_load(0, 0, KindCrystal);
    push_load(0, 1, KindEmpty);
    push_load(0, 2, KindWall);
    push_load(0, 3, KindCrystal);
    push_load(1, 0, KindSpare);
    push_load(1, 1, KindCrystal);
    push_load(1, 2, KindCrystal);
    push_load(1, 3, KindCrystal);
    push_load(2, 0, KindCrystal);
    push_load(2, 1, KindEmpty);
    push_load(2, 2, KindWall);
    push_load(2, 3, KindEmpty);
    for (int unsigned i = 0; i < 12; i++) push_query(loaded_cells[i]);
    push_load(1, 1, KindEmpty);
    push_query(0);

    // full-width first row and the far corners of the grid
    for (int unsigned c = 0; c < Cols; c++) begin
      push_load(0, c, (c == Cols - 1) ? KindCrystal : 2'($urandom_range(3, 0)));
      if ($urandom_range(99, 0) < 5) push_random_query();
    end
    push_load(DefMaxRows - 2, 0, KindWall);
    push_load(DefMaxRows - 1, 0, KindCrystal);
    push_load(DefMaxRows - 2, Cols - 1, KindWall);
    push_load(DefMaxRows - 1, Cols - 2, KindWall);
    push_load(DefMaxRows - 1, Cols - 1, KindCrystal);
    push_query(Cols - 1);
    push_query((DefMaxRows - 1) * Cols);
    push_query(DefMaxRows * Cols - 1);

    while (pending_ops.size() < 760) begin
      if ($urandom_range(9, 0) == 0) begin
        push_load(0, $urandom_range(Cols - 1, 0), 2'($urandom_range(3, 0)));
      end else begin
        load_grid($urandom_range(10, 2), $urandom_range(10, 2), 30);
      end
      push_random_query();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_ops.size() != 0 || in_valid || expected_counts.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
